[design/kts_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_pkg
// shared types and constants of the keyframe track sampler
// ---------------------------------------------------------------------------
package kts_pkg;

    localparam int DEFAULT_MAX_KEYS = 64;
    localparam int COUNT_W          = 7;
    localparam int IDX_W            = 6;
    localparam int FRAC_W           = 17;
    localparam int WORD_W           = 128;

    localparam logic [FRAC_W-1:0]  FRAC_ONE      = 17'h10000;
    localparam logic [COUNT_W-1:0] KEY_COUNT_RST = 7'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [5:0]        key_index;
        logic [31:0]       key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0]       query_time;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment;
        logic               past_end;
    } result_t;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_NEXT,
        RD_SEG
    } rd_sel_t;

    typedef struct packed {
        logic    wr;
        logic    start_sample;
        rd_sel_t rd_sel;
        logic    ptr_inc;
        logic    search_end;
        logic    lo_capture;
        logic    frac_setup;
        logic    div_step;
        logic    mul_step;
        logic    acc_step;
    } dp_cmd_t;

    typedef struct packed {
        logic single;
        logic hit;
        logic last;
        logic div_needed;
        logic div_last;
        logic comp_last;
    } dp_status_t;

endpackage

[design/keyframe_track_sampler.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyframe_track_sampler
// one animation track of vec3 keyframes with linear sampling
// ---------------------------------------------------------------------------
// a beat is taken when start is high and busy is low. a load beat writes one
// keyframe in that cycle and never raises busy, so loads can stream one per
// cycle. a sample beat raises busy and walks the key times one per cycle from
// key 1 until it finds the segment, reads the lower key, forms the q1.16
// fraction with a serial restoring divider when the query falls strictly
// inside a segment, then runs x, y and z through one shared multiplier. the
// key walk and the serial divider set how long a sample takes before the
// result strobe rises. result_strobe is high for a single cycle with the
// result on the result ports, and the receiver cannot stall it; busy is
// already low in that cycle so the next beat can be taken at once. key_count
// is to be written over the apb port only while the block is idle; the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
module keyframe_track_sampler #(
    parameter int MAX_KEYS = kts_pkg::DEFAULT_MAX_KEYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kts_pkg::item_t   item,
    output logic             result_strobe,
    output kts_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import kts_pkg::*;

    logic [COUNT_W-1:0] key_count_reg;
    logic [COUNT_W-1:0] key_count_next;
    logic               cfg_write;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // register 0 (key_count) sits at byte address 0, address 4 is unused
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        key_count_next = key_count_reg;
        if (cfg_write && !paddr[2])
            key_count_next = pwdata[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= KEY_COUNT_RST;
        else
            key_count_reg <= key_count_next;
    end

    always_comb
    begin
        if (!paddr[2])
            prdata = {{(32-COUNT_W){1'b0}}, key_count_reg};
        else
            prdata = '0;
    end

    // sequencer: owns the state and the result strobe
    kts_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (item.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (result_strobe)
    );

    // keyframe memory plus search, divide and lerp hardware
    kts_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .key_count (key_count_reg),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // the strobe marks a single cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for more than one cycle");

    // a sample only ends by delivering its result
    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_strobe)
        else $error("busy dropped without a result");

    // a load beat completes in its accept cycle
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.func == FUNC_LOAD) |=> !busy)
        else $error("load beat raised busy");

endmodule

[design/kts_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_datapath
// keyframe memory, segment search pointer, serial divider and shared lerp unit
// ---------------------------------------------------------------------------
module kts_datapath #(
    parameter int MAX_KEYS = kts_pkg::DEFAULT_MAX_KEYS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kts_pkg::item_t                item,
    input  logic [kts_pkg::COUNT_W-1:0]   key_count,
    input  kts_pkg::dp_cmd_t              cmd,
    output kts_pkg::dp_status_t           status,
    output kts_pkg::result_t              result
);
    import kts_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // word layout: time, x, y, z
    logic [WORD_W-1:0] mem [MAX_KEYS];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_ok;

    logic [31:0]        q_reg;
    logic [COUNT_W-1:0] n_reg;
    logic               single_reg;
    logic [COUNT_W-1:0] ptr_reg;
    logic [COUNT_W-1:0] seg_reg;
    logic               past_reg;
    logic [WORD_W-1:0]  lo_reg;
    logic [WORD_W-1:0]  hi_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        quot_reg;
    logic [3:0]         div_cnt_reg;
    logic signed [50:0] prod_reg;
    logic [1:0]         comp_reg;
    result_t            res_reg;

    logic [COUNT_W-1:0] n_now;
    logic [31:0]        t_lo;
    logic [31:0]        t_hi;
    logic [31:0]        num;
    logic [31:0]        den;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        comp_a;
    logic [31:0]        comp_b;
    logic signed [32:0] diff;
    logic signed [34:0] step;
    logic signed [35:0] sum;
    logic [31:0]        sat;

    // clamp the programmed count into 1..MAX_KEYS
    always_comb
    begin
        if (key_count == '0)
            n_now = COUNT_W'(1);
        else if (int'(key_count) > MAX_KEYS)
            n_now = COUNT_W'(MAX_KEYS);
        else
            n_now = key_count;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST: rd_addr = AW'(1);
            RD_NEXT:  rd_addr = AW'(ptr_reg + COUNT_W'(1));
            RD_SEG:   rd_addr = AW'(seg_reg);
            default:  rd_addr = AW'(seg_reg);
        endcase
    end

    assign wr_ok = cmd.wr && (int'(item.key_index) < MAX_KEYS);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[AW'(item.key_index)] <= {item.key_time, item.value_x,
                                         item.value_y, item.value_z};
        rdata_reg <= mem[rd_addr];
    end

    assign t_lo   = lo_reg[127:96];
    assign t_hi   = hi_reg[127:96];
    assign num    = q_reg - t_lo;
    assign den    = t_hi - t_lo;
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, den};

    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                comp_a = lo_reg[95:64];
                comp_b = hi_reg[95:64];
            end
            COMP_Y:
            begin
                comp_a = lo_reg[63:32];
                comp_b = hi_reg[63:32];
            end
            COMP_Z:
            begin
                comp_a = lo_reg[31:0];
                comp_b = hi_reg[31:0];
            end
            default:
            begin
                comp_a = lo_reg[31:0];
                comp_b = hi_reg[31:0];
            end
        endcase
    end

    assign diff = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
    // arithmetic shift gives floor division by 2^16
    assign step = prod_reg[50:16];
    assign sum  = $signed({{4{comp_a[31]}}, comp_a}) + $signed({step[34], step});
    always_comb
    begin
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111)
            sat = sum[31:0];
        else if (sum[35])
            sat = 32'h8000_0000;
        else
            sat = 32'h7fff_ffff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.frac_setup)
            begin
                comp_reg    <= '0;
                div_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.acc_step)
                    comp_reg <= comp_reg + 2'd1;
                if (cmd.div_step)
                    div_cnt_reg <= div_cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sample)
        begin
            q_reg      <= item.query_time;
            n_reg      <= n_now;
            single_reg <= (n_now == COUNT_W'(1));
            ptr_reg    <= COUNT_W'(1);
            seg_reg    <= '0;
            past_reg   <= 1'b0;
        end
        if (cmd.ptr_inc)
            ptr_reg <= ptr_reg + COUNT_W'(1);
        if (cmd.search_end)
        begin
            seg_reg  <= ptr_reg - COUNT_W'(1);
            past_reg <= !status.hit;
            hi_reg   <= rdata_reg;
        end
        if (cmd.lo_capture)
        begin
            lo_reg <= rdata_reg;
            if (single_reg)
                hi_reg <= rdata_reg;
        end
        if (cmd.frac_setup)
        begin
            rem_reg  <= num;
            quot_reg <= '0;
            if (single_reg)
            begin
                frac_reg <= '0;
                past_reg <= (q_reg >= t_lo);
            end
            else if (past_reg)
                frac_reg <= FRAC_ONE;
            else if (t_hi <= t_lo || q_reg <= t_lo)
                frac_reg <= '0;
            else if (num >= den)
                frac_reg <= FRAC_ONE;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
            quot_reg <= {quot_reg[14:0], rem_ge};
            if (status.div_last)
                frac_reg <= {1'b0, quot_reg[14:0], rem_ge};
        end
        if (cmd.mul_step)
            prod_reg <= diff * $signed({1'b0, frac_reg});
        if (cmd.acc_step)
        begin
            case (comp_reg)
                COMP_X:  res_reg.out_x <= sat;
                COMP_Y:  res_reg.out_y <= sat;
                COMP_Z:  res_reg.out_z <= sat;
                default: res_reg.out_z <= sat;
            endcase
            res_reg.segment  <= seg_reg[IDX_W-1:0];
            res_reg.past_end <= past_reg;
        end
    end

    always_comb
    begin
        status.single     = single_reg;
        status.hit        = q_reg < rdata_reg[127:96];
        status.last       = (ptr_reg == n_reg - COUNT_W'(1));
        status.div_needed = !single_reg && !past_reg && (t_hi > t_lo)
                            && (q_reg > t_lo) && (num < den);
        status.div_last   = (div_cnt_reg == 4'd15);
        status.comp_last  = (comp_reg == COMP_Z);
    end

    assign result = res_reg;

endmodule

[design/kts_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_controller
// sequencer for load and sample items: search, fetch, divide, interpolate
// ---------------------------------------------------------------------------
module kts_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 func,
    input  kts_pkg::dp_status_t  status,
    output kts_pkg::dp_cmd_t     cmd,
    output logic                 busy,
    output logic                 done
);
    import kts_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        FETCH_LO,
        LO_WAIT,
        FRAC,
        DIV,
        MUL,
        ACC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_SEG;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_LOAD)
                        cmd.wr = 1'b1;
                    else
                    begin
                        cmd.start_sample = 1'b1;
                        cmd.rd_sel       = RD_FIRST;
                        state_next       = SEARCH;
                    end
                end
            end
            SEARCH:
            begin
                cmd.rd_sel = RD_NEXT;
                if (status.single)
                    state_next = FETCH_LO;
                else if (status.hit || status.last)
                begin
                    cmd.search_end = 1'b1;
                    state_next     = FETCH_LO;
                end
                else
                    cmd.ptr_inc = 1'b1;
            end
            FETCH_LO:
            begin
                state_next = LO_WAIT;
            end
            LO_WAIT:
            begin
                cmd.lo_capture = 1'b1;
                state_next     = FRAC;
            end
            FRAC:
            begin
                cmd.frac_setup = 1'b1;
                state_next     = status.div_needed ? DIV : MUL;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = MUL;
            end
            MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ACC;
            end
            ACC:
            begin
                cmd.acc_step = 1'b1;
                if (status.comp_last)
                begin
                    done_next  = 1'b1;
                    state_next = IDLE;
                end
                else
                    state_next = MUL;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != IDLE);
    assign done = done_reg;

endmodule
